>>> design/stg_pkg.sv
package stg_pkg;

   localparam int FREQ_W       = 25;
   localparam int RATE_W       = 18;
   localparam int MODE_W       = 2;
   localparam int SAMPLE_W     = 32;
   localparam int INDEX_W      = 24;
   localparam int PERIOD_W     = 40;
   localparam int PHASE_W      = 16;
   localparam int POS_W        = 14;
   localparam int ENTRY_W      = 31;
   localparam int SCALE_W      = 31;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 18;
   localparam int QUEUE_DEPTH  = 2;

   localparam int QUARTER_TABLE_DEPTH_DEF = 1024;

   localparam logic [RATE_W-1:0]   SAMPLE_RATE_RST = RATE_W'(48000);
   localparam logic [MODE_W-1:0]   WIDTH_MODE_RST  = '0;
   localparam logic [PERIOD_W-1:0] PERIOD_MAX      = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_MODE  = CSR_IDX_W'(1);

   localparam logic [MODE_W-1:0] WM_16 = MODE_W'(0);
   localparam logic [MODE_W-1:0] WM_24 = MODE_W'(1);

   localparam logic [SCALE_W-1:0] SCALE_16 = SCALE_W'(32767);
   localparam logic [SCALE_W-1:0] SCALE_24 = SCALE_W'(16777215);
   localparam logic [SCALE_W-1:0] SCALE_32 = SCALE_W'(2147483647);

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint          ONE_Q30     = 64'sd1073741824;

   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [PERIOD_W-1:0] period;
   } stg_job_type;

   typedef enum logic [1:0] {
      FS_IDLE,
      FS_DIV_FIRST,
      FS_ISSUE,
      FS_DIV_WRAP
   } front_state_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_DIV,
      BS_LOOK,
      BS_MUL,
      BS_OUT
   } back_state_type;

endpackage

>>> design/stg_front.sv
module stg_front import stg_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [FREQ_W-1:0]   req_target_freq,
   input  logic [RATE_W-1:0]   sample_rate,
   output logic                job_valid,
   input  logic                job_ready,
   output stg_job_type         job
);

   localparam int CNT_W = $clog2(PERIOD_W);

   front_state_type       state_ff, state_in;
   logic [FREQ_W-1:0]     freq_ff, freq_in;
   logic [FREQ_W-1:0]     taken_ff, taken_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic                  started_ff, started_in;
   logic [FREQ_W-1:0]     rem_ff, rem_in;
   logic [PERIOD_W-1:0]   dq_ff, dq_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic                  chk_en;
   logic                  div_busy;
   logic [FREQ_W-1:0]     chk_freq;
   logic                  chk_diff;
   logic                  chk_sat;
   logic [INDEX_W:0]      inc;
   logic                  wrap;
   logic                  last_step;
   logic [FREQ_W:0]       trial;
   logic                  ge;

   assign chk_freq  = (state_ff == FS_IDLE) ? req_target_freq : freq_ff;
   assign chk_diff  = chk_freq != taken_ff;
   assign chk_sat   = chk_freq <= {(FREQ_W-2)'(0), sample_rate[RATE_W-1 -: 2]};
   assign inc       = {1'b0, index_ff} + (INDEX_W+1)'(1);
   assign wrap      = {inc, PHASE_W'(0)} >= {1'b0, period_ff};
   assign last_step = cnt_ff == CNT_W'(PERIOD_W - 1);
   assign trial     = {rem_ff, dq_ff[PERIOD_W-1]};
   assign ge        = trial >= {1'b0, freq_ff};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FS_IDLE: begin
            if (req_valid) begin
               if (!started_ff && chk_diff && !chk_sat) state_in = FS_DIV_FIRST;
               else state_in = FS_ISSUE;
            end
         end
         FS_DIV_FIRST: begin
            if (last_step) state_in = FS_ISSUE;
         end
         FS_ISSUE: begin
            if (job_ready) begin
               if (wrap && chk_diff && !chk_sat) state_in = FS_DIV_WRAP;
               else state_in = FS_IDLE;
            end
         end
         FS_DIV_WRAP: begin
            if (last_step) state_in = FS_IDLE;
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      job_valid = 1'b0;
      chk_en    = 1'b0;
      div_busy  = 1'b0;
      case (state_ff)
         FS_IDLE: begin
            req_ready = 1'b1;
            chk_en    = req_valid && !started_ff;
         end
         FS_ISSUE: begin
            job_valid = 1'b1;
            chk_en    = job_ready && wrap;
         end
         FS_DIV_FIRST, FS_DIV_WRAP: begin
            div_busy = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign job.index  = index_ff;
   assign job.period = period_ff;

   always_comb begin
      freq_in    = freq_ff;
      taken_in   = taken_ff;
      period_in  = period_ff;
      index_in   = index_ff;
      started_in = started_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      cnt_in     = cnt_ff;
      if (req_ready && req_valid) begin
         freq_in = req_target_freq;
         if (!started_ff) begin
            index_in   = '0;
            started_in = 1'b1;
         end
      end
      if (job_valid && job_ready) begin
         index_in = wrap ? '0 : inc[INDEX_W-1:0];
      end
      if (chk_en && chk_diff) begin
         if (chk_sat) begin
            period_in = PERIOD_MAX;
            taken_in  = chk_freq;
         end else begin
            rem_in = {(FREQ_W-2)'(0), sample_rate[RATE_W-1 -: 2]};
            dq_in  = {sample_rate[RATE_W-3:0], (PERIOD_W-RATE_W+2)'(0)};
            cnt_in = '0;
         end
      end
      if (div_busy) begin
         rem_in = ge ? FREQ_W'(trial - {1'b0, freq_ff}) : trial[FREQ_W-1:0];
         dq_in  = {dq_ff[PERIOD_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (last_step) begin
            period_in = {dq_ff[PERIOD_W-2:0], ge};
            taken_in  = freq_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FS_IDLE;
         taken_ff   <= '0;
         period_ff  <= '0;
         index_ff   <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         taken_ff   <= taken_in;
         period_ff  <= period_in;
         index_ff   <= index_in;
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      freq_ff <= freq_in;
      rem_ff  <= rem_in;
      dq_ff   <= dq_in;
      cnt_ff  <= cnt_in;
   end

endmodule

>>> design/stg_queue.sv
module stg_queue import stg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  stg_job_type   in_job,
   output logic          out_valid,
   input  logic          out_ready,
   output stg_job_type   out_job
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   stg_job_type        mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = count_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_job   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_job;
   end

endmodule

>>> design/stg_back.sv
module stg_back import stg_pkg::*; #(
   parameter int QUARTER_TABLE_DEPTH = QUARTER_TABLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       job_valid,
   output logic                       job_ready,
   input  stg_job_type                job,
   input  logic [MODE_W-1:0]          width_mode,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_sample
);

   localparam int ADDR_W = $clog2(QUARTER_TABLE_DEPTH + 1);
   localparam int MUL_W  = POS_W + ADDR_W;
   localparam int CNT_W  = $clog2(PHASE_W);
   localparam int PROD_W = ENTRY_W + SCALE_W;

   typedef logic [ENTRY_W-1:0] qtab_type [QUARTER_TABLE_DEPTH + 1];

   function automatic longint unsigned udiv64(longint unsigned num, longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = 0;
      rem = 0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], num[b]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [ENTRY_W-1:0] sine_q30(longint unsigned a);
      longint          sum;
      longint unsigned term;
      longint unsigned n;
      logic            neg;
      sum  = longint'(a);
      term = a;
      neg  = 1'b1;
      for (n = 1; n < 17; n += 2) begin
         term = (term * a) >> 30;
         term = (term * a) >> 30;
         term = udiv64(term, (n + 1) * (n + 2));
         if (neg) sum -= longint'(term);
         else sum += longint'(term);
         neg = !neg;
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      return ENTRY_W'(sum);
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int k = 0; k <= QUARTER_TABLE_DEPTH; k++) begin
         t[k] = sine_q30(udiv64(HALF_PI_Q30 * longint'(k), 64'(QUARTER_TABLE_DEPTH)));
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   back_state_type            state_ff, state_in;
   logic [PERIOD_W-1:0]       rem_ff, rem_in;
   logic [PERIOD_W-1:0]       per_ff, per_in;
   logic [PHASE_W-1:0]        q_ff, q_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [ENTRY_W-1:0]        entry_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]       sample_ff;

   logic                      load;
   logic                      div_run;
   logic                      last_step;
   logic                      out_load;
   logic [PERIOD_W:0]         trial;
   logic                      ge;
   logic [MUL_W-1:0]          pos_mul;
   logic [ADDR_W-1:0]         idx;
   logic [ADDR_W-1:0]         addr;
   logic [SCALE_W-1:0]        scale;
   logic [SAMPLE_W-1:0]       mag;
   logic                      out_free;

   assign last_step = cnt_ff == CNT_W'(PHASE_W - 1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign trial     = {rem_ff, 1'b0};
   assign ge        = (trial >= {1'b0, per_ff}) && (per_ff != '0);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BS_IDLE: if (job_valid) state_in = BS_DIV;
         BS_DIV:  if (last_step) state_in = BS_LOOK;
         BS_LOOK: state_in = BS_MUL;
         BS_MUL:  state_in = BS_OUT;
         BS_OUT:  if (out_free) state_in = BS_IDLE;
         default: state_in = BS_IDLE;
      endcase
   end

   always_comb begin
      job_ready = 1'b0;
      div_run   = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         BS_IDLE: job_ready = 1'b1;
         BS_DIV:  div_run   = 1'b1;
         BS_OUT:  out_load  = out_free;
         default: job_ready = 1'b0;
      endcase
   end

   assign load = job_valid && job_ready;

   always_comb begin
      rem_in = rem_ff;
      per_in = per_ff;
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (load) begin
         rem_in = {job.index, PHASE_W'(0)};
         per_in = job.period;
         cnt_in = '0;
      end
      if (div_run) begin
         rem_in = ge ? PERIOD_W'(trial - {1'b0, per_ff}) : trial[PERIOD_W-1:0];
         q_in   = {q_ff[PHASE_W-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_comb begin
      pos_mul = MUL_W'(q_ff[POS_W-1:0]) * MUL_W'(QUARTER_TABLE_DEPTH);
      idx     = pos_mul[MUL_W-1:POS_W];
      addr    = q_ff[POS_W] ? ADDR_W'(QUARTER_TABLE_DEPTH) - idx : idx;
   end

   always_comb begin
      case (width_mode)
         WM_16:   scale = SCALE_16;
         WM_24:   scale = SCALE_24;
         default: scale = SCALE_32;
      endcase
   end

   assign mag = prod_ff[PROD_W-1:30];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      per_ff <= per_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (state_ff == BS_LOOK) entry_ff <= QTAB[addr];
      if (state_ff == BS_MUL) prod_ff <= PROD_W'(entry_ff) * PROD_W'(scale);
      if (out_load) sample_ff <= q_ff[PHASE_W-1] ? SAMPLE_W'(0) - mag : mag;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = sample_ff;

endmodule

>>> design/sine_tone_generator_core.sv
// Channel   Ports                                      Direction
// request   req_valid, req_ready, req_target_freq      in
// result    rsp_valid, rsp_ready, rsp_left_sample,     out
//           rsp_right_sample
// config    csr_write_enable, csr_index, csr_write_data in
//
// Front takes a new request only after its last job has entered the queue; a period
// divide (one quotient bit per cycle) is added on the first request and at a wrap with a
// new frequency. Back works each sample through 16 phase divide steps, table read,
// multiply, output, and takes a new job only once rsp_ready lets it load its output.
// Synchronous reset; no clearing pass. A two-entry queue lets front and back stall apart.
module sine_tone_generator_core import stg_pkg::*; #(
   parameter int QUARTER_TABLE_DEPTH = QUARTER_TABLE_DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [FREQ_W-1:0]          req_target_freq,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_left_sample,
   output logic signed [SAMPLE_W-1:0] rsp_right_sample,
   input  logic                       csr_write_enable,
   input  logic [CSR_IDX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_write_data
);

   logic [RATE_W-1:0]          sample_rate_ff, sample_rate_in;
   logic [MODE_W-1:0]          width_mode_ff, width_mode_in;
   logic                       push_valid;
   logic                       push_ready;
   stg_job_type                push_job;
   logic                       pop_valid;
   logic                       pop_ready;
   stg_job_type                pop_job;
   logic signed [SAMPLE_W-1:0] sample;

   always_comb begin
      sample_rate_in = sample_rate_ff;
      width_mode_in  = width_mode_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SAMPLE_RATE: sample_rate_in = csr_write_data[RATE_W-1:0];
            CSR_WIDTH_MODE:  width_mode_in  = csr_write_data[MODE_W-1:0];
            default:         width_mode_in  = width_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= SAMPLE_RATE_RST;
         width_mode_ff  <= WIDTH_MODE_RST;
      end else begin
         sample_rate_ff <= sample_rate_in;
         width_mode_ff  <= width_mode_in;
      end
   end

   stg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_target_freq (req_target_freq),
      .sample_rate     (sample_rate_ff),
      .job_valid       (push_valid),
      .job_ready       (push_ready),
      .job             (push_job)
   );

   stg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_job    (push_job),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_job   (pop_job)
   );

   stg_back #(
      .QUARTER_TABLE_DEPTH (QUARTER_TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (pop_valid),
      .job_ready  (pop_ready),
      .job        (pop_job),
      .width_mode (width_mode_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (sample)
   );

   assign rsp_left_sample  = sample;
   assign rsp_right_sample = sample;

endmodule

>>> sim/tb_sine_tone_generator_core.sv
`timescale 1ns / 1ps

module tb_sine_tone_generator_core;
   import stg_pkg::*;

   typedef longint unsigned u64_t;

   localparam int TABLE_DEPTH  = QUARTER_TABLE_DEPTH_DEF;
   localparam int DRAIN_CYCLES = 64;
   localparam int STUCK_LIMIT  = 2000;

   localparam logic [MODE_W-1:0] WM_32     = MODE_W'(2);
   localparam logic [MODE_W-1:0] WM_32_ALT = MODE_W'(3);

   localparam logic [FREQ_W-1:0] FREQ_TOP      = FREQ_W'(24576000);
   localparam logic [FREQ_W-1:0] FREQ_ALL_ONES = '1;
   localparam logic [FREQ_W-1:0] FREQ_QUARTER  = FREQ_W'(3072000);
   localparam logic [FREQ_W-1:0] FREQ_THIRD    = FREQ_W'(4096000);

   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_ready;
   logic [FREQ_W-1:0]          req_target_freq  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_left_sample;
   logic signed [SAMPLE_W-1:0] rsp_right_sample;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index        = CSR_SAMPLE_RATE;
   logic [CSR_DATA_W-1:0]      csr_write_data   = '0;

   sine_tone_generator_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_freq  (req_target_freq),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_left_sample  (rsp_left_sample),
      .rsp_right_sample (rsp_right_sample),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // tone model state
   u64_t                sine_table [0:TABLE_DEPTH];
   logic [RATE_W-1:0]   tone_rate;
   logic [MODE_W-1:0]   tone_mode;
   logic [31:0]         tone_index;
   logic [PERIOD_W-1:0] tone_period;
   logic [FREQ_W-1:0]   tone_freq;
   logic                tone_started;

   logic signed [SAMPLE_W-1:0] expected_samples [$];
   logic signed [SAMPLE_W-1:0] want_sample;

   bit idle_on = 1'b0;
   int fail_count   = 0;
   int stuck_cycles = 0;
   int rsp_count    = 0;
   int rsp_seen     = 0;
   int rsp_hold     = 0;

   function automatic u64_t taylor_sine_q30(input u64_t a);
      longint sum;
      u64_t    term;
      int      sgn;
      sum  = longint'(a);
      term = a;
      sgn  = -1;
      for (int n = 1; n < 17; n += 2) begin
         term = (term * a) >> 30;
         term = (term * a) >> 30;
         term = term / u64_t'((n + 1) * (n + 2));
         if (sgn < 0) sum = sum - longint'(term);
         else sum = sum + longint'(term);
         sgn = -sgn;
      end
      if (sum < 0) sum = 0;
      if (sum > ONE_Q30) sum = ONE_Q30;
      return u64_t'(sum);
   endfunction

   function automatic void retune_period(input logic [FREQ_W-1:0] freq);
      u64_t quot;
      if (freq == tone_freq) return;
      if (freq == '0) begin
         quot = u64_t'(PERIOD_MAX);
      end else begin
         quot = (u64_t'(tone_rate) << 24) / u64_t'(freq);
         if (quot > u64_t'(PERIOD_MAX)) quot = u64_t'(PERIOD_MAX);
      end
      tone_period = quot[PERIOD_W-1:0];
      tone_freq   = freq;
   endfunction

   function automatic logic [SAMPLE_W-1:0] next_tone_sample(input logic [FREQ_W-1:0] freq);
      u64_t                phase;
      u64_t                slot;
      u64_t                scale;
      u64_t                mag;
      logic [1:0]          quad;
      logic [SAMPLE_W-1:0] sample;
      if (!tone_started) begin
         retune_period(freq);
         tone_index   = '0;
         tone_started = 1'b1;
      end
      phase = 0;
      if (tone_period != '0)
         phase = ((u64_t'(tone_index) << 32) / u64_t'(tone_period)) & 64'hFFFF;
      quad = phase[15:14];
      slot = ((phase & 64'h3FFF) * TABLE_DEPTH) >> 14;
      if (slot > TABLE_DEPTH) slot = TABLE_DEPTH;
      if (quad[0]) slot = TABLE_DEPTH - slot;
      case (tone_mode)
         WM_16: scale = u64_t'(SCALE_16);
         WM_24: scale = u64_t'(SCALE_24);
         default: scale = u64_t'(SCALE_32);
      endcase
      mag = (sine_table[slot] * scale) >> 30;
      if (mag > scale) mag = scale;
      sample = mag[SAMPLE_W-1:0];
      if (quad[1]) sample = -sample;
      tone_index = tone_index + 1;
      if ((u64_t'(tone_index) << 16) >= u64_t'(tone_period)) begin
         tone_index = '0;
         retune_period(freq);
      end
      return sample;
   endfunction

   task automatic send_tone_request(input logic [FREQ_W-1:0] freq);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 14) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_target_freq <= freq;
      do @(posedge clock); while (!req_ready);
      expected_samples.push_back(next_tone_sample(freq));
      @(negedge clock);
   endtask

   task automatic settle_tone_block();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_tone_config(input logic [RATE_W-1:0] rate,
                                    input logic [CSR_DATA_W-1:0] mode_word);
      settle_tone_block();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_SAMPLE_RATE;
      csr_write_data   <= CSR_DATA_W'(rate);
      tone_rate = rate;
      @(negedge clock);
      csr_index      <= CSR_WIDTH_MODE;
      csr_write_data <= mode_word;
      tone_mode = mode_word[MODE_W-1:0];
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [CSR_DATA_W-1:0] mode_word_of(input logic [MODE_W-1:0] mode);
      return CSR_DATA_W'({16'($urandom()), mode});
   endfunction

   // first request with zero frequency keeps a zero period
   task automatic zero_period_test();
      idle_on = 1'b0;
      repeat (3) send_tone_request('0);
      send_tone_request(FREQ_TOP);
      send_tone_request(FREQ_ALL_ONES);
      repeat (5) send_tone_request(FREQ_THIRD);
   endtask

   // four-sample period walks the quadrant boundaries in every mode
   task automatic width_mode_test();
      logic [MODE_W-1:0] modes [4] = '{WM_16, WM_24, WM_32, WM_32_ALT};
      idle_on = 1'b1;
      write_tone_config(RATE_W'(48000), mode_word_of(WM_16));
      while (tone_freq != FREQ_QUARTER) send_tone_request(FREQ_QUARTER);
      for (int m = 0; m < 4; m++) begin
         if (m > 0) write_tone_config(RATE_W'(48000), mode_word_of(modes[m]));
         repeat (4) send_tone_request(FREQ_QUARTER);
      end
   endtask

   task automatic random_tone_test();
      logic [RATE_W-1:0] rate;
      logic [FREQ_W-1:0] freq;
      u64_t              span;
      u64_t              lo;
      int unsigned       count;
      int unsigned       n;
      int unsigned       len;
      for (int ph = 0; ph < 10; ph++) begin
         if (ph == 0) begin
            rate = RATE_W'(8000);
         end else if (ph == 1) begin
            rate = RATE_W'(192000);
         end else begin
            case ($urandom_range(0, 7))
               0: rate = RATE_W'(8000);
               1: rate = RATE_W'(192000);
               2: rate = RATE_W'(48000);
               3: rate = RATE_W'(44100);
               4: rate = '1;
               5: rate = '0;
               default: rate = RATE_W'($urandom_range(8000, 192000));
            endcase
         end
         write_tone_config(rate, mode_word_of(MODE_W'($urandom_range(0, 3))));
         idle_on = ($urandom_range(0, 3) != 0);
         lo = (u64_t'(rate) * 256) / 400;
         if (lo == 0) lo = 1;
         count = 0;
         while (count < 140) begin
            if ($urandom_range(0, 4) != 0) begin
               // steady tone held for a few periods
               n    = $urandom_range(1, 48);
               span = (u64_t'(rate) * 256) / n + $urandom_range(0, 255);
               if (span == 0) span = 1;
               if (span > u64_t'(FREQ_ALL_ONES)) span = u64_t'(FREQ_ALL_ONES);
               freq = span[FREQ_W-1:0];
               len  = n * $urandom_range(1, 3) + $urandom_range(0, 2);
               repeat (len) send_tone_request(freq);
            end else begin
               len = $urandom_range(1, 6);
               repeat (len)
                  send_tone_request(FREQ_W'($urandom_range(32'(lo), 32'(FREQ_ALL_ONES))));
            end
            count += len;
            if ($urandom_range(0, 9) == 0) idle_on = !idle_on;
         end
      end
   endtask

   // saturates the period, so it has to run last
   task automatic oversized_period_test();
      idle_on = 1'b1;
      write_tone_config(RATE_W'(192000), mode_word_of(MODE_W'($urandom_range(0, 3))));
      while (tone_freq != FREQ_ALL_ONES) send_tone_request(FREQ_ALL_ONES);
      while (tone_freq != FREQ_W'(1)) send_tone_request(FREQ_W'(1));
      repeat (6) send_tone_request(FREQ_W'($urandom()));
   endtask

   always @(negedge clock) begin
      if (rsp_count != rsp_seen) begin
         rsp_seen = rsp_count;
         rsp_hold = idle_on ? $urandom_range(0, 14) : 0;
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_samples.size() == 0) begin
               $error("result with no request pending: left_sample %0d", rsp_left_sample);
               fail_count = fail_count + 1;
            end else begin
               want_sample = expected_samples.pop_front();
               if (rsp_left_sample !== want_sample) begin
                  $error("left_sample: expected %0d, actual %0d", want_sample, rsp_left_sample);
                  fail_count = fail_count + 1;
               end
               if (rsp_right_sample !== want_sample) begin
                  $error("right_sample: expected %0d, actual %0d", want_sample,
                         rsp_right_sample);
                  fail_count = fail_count + 1;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   initial begin
      for (u64_t k = 0; k <= TABLE_DEPTH; k++)
         sine_table[k] = taylor_sine_q30((HALF_PI_Q30 * k) / TABLE_DEPTH);
      tone_rate    = SAMPLE_RATE_RST;
      tone_mode    = WIDTH_MODE_RST;
      tone_index   = '0;
      tone_period  = '0;
      tone_freq    = '0;
      tone_started = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      zero_period_test();
      width_mode_test();
      random_tone_test();
      oversized_period_test();
      settle_tone_block();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
